// ===== hdl/mcpp_pkg.sv =====
// Shared types, codes and limits of the MQTT packet parser core.
package mcpp_pkg;

	localparam int PACKET_MAX_DEF  = 512;
	localparam int TOPIC_MAX_DEF   = 64;
	localparam int PAYLOAD_MAX_DEF = 256;
	localparam int QUEUE_DEPTH     = 4;
	localparam int QCW             = $clog2(QUEUE_DEPTH + 1);
	localparam int QAW             = $clog2(QUEUE_DEPTH);

	localparam logic [1:0] ST_MORE  = 2'd0;
	localparam logic [1:0] ST_ERR   = 2'd1;
	localparam logic [1:0] ST_READY = 2'd2;
	localparam logic [1:0] ST_READ  = 2'd3;

	localparam logic [3:0] PT_CONNACK  = 4'd2;
	localparam logic [3:0] PT_PUBLISH  = 4'd3;
	localparam logic [3:0] PT_PUBACK   = 4'd4;
	localparam logic [3:0] PT_SUBACK   = 4'd9;
	localparam logic [3:0] PT_UNSUBACK = 4'd11;
	localparam logic [3:0] PT_PINGRESP = 4'd13;

	localparam logic [7:0] RC_FAIL = 8'h80;

	typedef enum logic [1:0] {
		K_MORE,
		K_ERR,
		K_CHECK,
		K_READ
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  first_byte;
		logic [15:0] rem;
		logic [2:0]  len_bytes;
		logic [15:0] word;
		logic [15:0] pair;
		logic [7:0]  sub_rc;
		logic [7:0]  rdata;
	} ent_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic [8:0] payload_size;
		logic [8:0] payload_start;
		logic [6:0] topic_size;
		logic [8:0] topic_start;
		logic [7:0] ret_code;
		logic       sess_flag;
		logic [15:0] pkt_ident;
		logic [3:0] header_flags;
		logic [3:0] packet_type;
		logic [1:0] status;
	} res_t;

endpackage

// ===== hdl/mcpp_front.sv =====
// Front end: frames received bytes, keeps the packet store and classifies each request.
module mcpp_front #(
	parameter int PACKET_MAX = mcpp_pkg::PACKET_MAX_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              acc,
	input  logic              cmd,
	input  logic [7:0]        data_byte,
	input  logic [8:0]        read_index,
	output logic              push,
	output mcpp_pkg::ent_t    push_ent
);
	import mcpp_pkg::*;

	localparam int AW  = $clog2(PACKET_MAX);
	localparam int BCW = $clog2(PACKET_MAX + 1);
	localparam logic [BCW-1:0] PMAX = BCW'(PACKET_MAX);

	logic [7:0]     mem [PACKET_MAX];
	logic [7:0]     rd_s1;
	logic           rd_ok_s1;
	logic           valid_s1;
	ent_t           ent_s1;

	logic [BCW-1:0] bc_q, bc_n, body_q, body_n, total_q, total_n;
	logic [27:0]    lv_q, lv_n;
	logic [2:0]     lbu_q, lbu_n;
	logic           ld_q, ld_n;
	logic [7:0]     fb_q, fb_n;
	logic [15:0]    word_q, word_n, pair_q, pair_n, rem_q, rem_n;
	logic [7:0]     rc_q, rc_n;
	logic [27:0]    add_v;
	logic [28:0]    tot;
	logic           we, restart;
	kind_t          kind;
	logic [15:0]    ri_ext;
	logic           ri_ok;
	logic [16:0]    off17, w2;

	assign ri_ext = {7'd0, read_index};
	assign ri_ok  = 32'(ri_ext) < 32'(PACKET_MAX);
	assign off17  = 17'(body_q);
	assign w2     = {1'b0, word_q} + 17'd2;

	always_comb begin
		bc_n    = bc_q;
		body_n  = body_q;
		total_n = total_q;
		lv_n    = lv_q;
		lbu_n   = lbu_q;
		ld_n    = ld_q;
		fb_n    = fb_q;
		word_n  = word_q;
		pair_n  = pair_q;
		rc_n    = rc_q;
		rem_n   = rem_q;
		we      = 1'b0;
		restart = 1'b0;
		kind    = K_MORE;
		add_v   = 28'd0;
		tot     = 29'd0;
		if (cmd) begin
			kind = K_READ;
		end else if (bc_q >= PMAX) begin
			kind    = K_ERR;
			restart = 1'b1;
		end else begin
			we   = 1'b1;
			bc_n = bc_q + 1'b1;
			if (bc_q == '0) begin
				fb_n = data_byte;
			end else if (!ld_q) begin
				case (bc_q[2:0])
					3'd1:    add_v = {21'd0, data_byte[6:0]};
					3'd2:    add_v = {14'd0, data_byte[6:0], 7'd0};
					3'd3:    add_v = {7'd0, data_byte[6:0], 14'd0};
					default: add_v = {data_byte[6:0], 21'd0};
				endcase
				lv_n  = lv_q + add_v;
				lbu_n = bc_q[2:0];
				if (data_byte[7]) begin
					if (bc_q >= BCW'(4)) begin
						kind    = K_ERR;
						restart = 1'b1;
					end
				end else begin
					ld_n    = 1'b1;
					tot     = 29'd1 + 29'(lbu_n) + {1'b0, lv_n};
					total_n = tot[BCW-1:0];
					rem_n   = lv_n[15:0];
					if (tot > 29'(PACKET_MAX)) begin
						kind    = K_ERR;
						restart = 1'b1;
					end else if (29'(bc_n) == tot) begin
						kind    = K_CHECK;
						restart = 1'b1;
					end
				end
			end else begin
				body_n = body_q + 1'b1;
				if (off17 < 17'd2) begin
					word_n = {word_q[7:0], data_byte};
				end else if (off17 == w2 || off17 == w2 + 17'd1) begin
					pair_n = {pair_q[7:0], data_byte};
				end
				if (off17 == 17'd2) begin
					rc_n = data_byte;
				end
				if (bc_n == total_q) begin
					kind    = K_CHECK;
					restart = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bc_q     <= '0;
			body_q   <= '0;
			total_q  <= '0;
			lv_q     <= '0;
			lbu_q    <= '0;
			ld_q     <= 1'b0;
			fb_q     <= '0;
			word_q   <= '0;
			pair_q   <= '0;
			rc_q     <= '0;
			rem_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= acc;
			if (acc) begin
				if (restart) begin
					bc_q    <= '0;
					body_q  <= '0;
					total_q <= '0;
					lv_q    <= '0;
					lbu_q   <= '0;
					ld_q    <= 1'b0;
					fb_q    <= '0;
					word_q  <= '0;
					pair_q  <= '0;
					rc_q    <= '0;
					rem_q   <= '0;
				end else begin
					bc_q    <= bc_n;
					body_q  <= body_n;
					total_q <= total_n;
					lv_q    <= lv_n;
					lbu_q   <= lbu_n;
					ld_q    <= ld_n;
					fb_q    <= fb_n;
					word_q  <= word_n;
					pair_q  <= pair_n;
					rc_q    <= rc_n;
					rem_q   <= rem_n;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc && we) begin
			mem[bc_q[AW-1:0]] <= data_byte;
		end
		if (acc && cmd) begin
			rd_s1 <= mem[ri_ext[AW-1:0]];
		end
		if (acc) begin
			rd_ok_s1          <= ri_ok;
			ent_s1.kind       <= kind;
			ent_s1.first_byte <= fb_n;
			ent_s1.rem        <= rem_n;
			ent_s1.len_bytes  <= lbu_n;
			ent_s1.word       <= word_n;
			ent_s1.pair       <= pair_n;
			ent_s1.sub_rc     <= rc_n;
			ent_s1.rdata      <= '0;
		end
	end

	always_comb begin
		push_ent       = ent_s1;
		push_ent.rdata = (ent_s1.kind == K_READ && rd_ok_s1) ? rd_s1 : 8'd0;
	end

	assign push = valid_s1;

endmodule

// ===== hdl/mcpp_fifo.sv =====
// Short request queue between the front end and the back end.
module mcpp_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  mcpp_pkg::ent_t push_ent,
	input  logic           pop,
	output logic           not_empty,
	output mcpp_pkg::ent_t head,
	output logic [mcpp_pkg::QCW-1:0] count
);
	import mcpp_pkg::*;

	ent_t           slot_q [QUEUE_DEPTH];
	logic [QAW-1:0] wp_q, rp_q;
	logic [QCW-1:0] cnt_q;

	assign not_empty = cnt_q != '0;
	assign head      = slot_q[rp_q];
	assign count     = cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= rp_q + 1'b1;
			end
			cnt_q <= cnt_q + QCW'(push) - QCW'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wp_q] <= push_ent;
		end
	end

endmodule

// ===== hdl/mcpp_back.sv =====
// Back end: validates complete packets, passes on read data and errors, and holds the result register.
module mcpp_back #(
	parameter int TOPIC_MAX   = mcpp_pkg::TOPIC_MAX_DEF,
	parameter int PAYLOAD_MAX = mcpp_pkg::PAYLOAD_MAX_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           not_empty,
	input  mcpp_pkg::ent_t head,
	output logic           pop,
	output logic           out_valid,
	input  logic           out_ready,
	output mcpp_pkg::res_t res
);
	import mcpp_pkg::*;

	logic        vld_q;
	res_t        res_q, r;
	logic [3:0]  ptype, flags;
	logic [1:0]  qos;
	logic [16:0] rem17, w17, avail, rest, pl, hdr, pos;
	logic        ok;

	assign pop       = not_empty && (!vld_q || out_ready);
	assign out_valid = vld_q;
	assign res       = res_q;

	always_comb begin
		ptype = head.first_byte[7:4];
		flags = head.first_byte[3:0];
		qos   = flags[2:1];
		rem17 = {1'b0, head.rem};
		w17   = {1'b0, head.word};
		hdr   = 17'd1 + 17'(head.len_bytes);
		avail = rem17 - 17'd2;
		rest  = avail - w17;
		pl    = (qos != 2'd0) ? rest - 17'd2 : rest;
		pos   = hdr + 17'd2 + w17 + ((qos != 2'd0) ? 17'd2 : 17'd0);
		ok    = 1'b0;
		r     = '0;
		case (head.kind)
			K_READ: begin
				r.status    = ST_READ;
				r.read_data = head.rdata;
			end
			K_ERR: begin
				r.status = ST_ERR;
			end
			K_CHECK: begin
				r.packet_type  = ptype;
				r.header_flags = flags;
				case (ptype)
					PT_CONNACK: begin
						ok = flags == 4'd0 && head.rem == 16'd2 && head.word[15:8] <= 8'd1;
						r.sess_flag = head.word[8];
						r.ret_code  = head.word[7:0];
					end
					PT_PUBLISH: begin
						ok = qos < 2'd2 && rem17 >= 17'd2 && w17 <= avail
							&& w17 < 17'(TOPIC_MAX);
						if (qos != 2'd0) begin
							ok = ok && rest >= 17'd2 && head.pair != 16'd0;
							r.pkt_ident = head.pair;
						end
						ok              = ok && pl <= 17'(PAYLOAD_MAX);
						r.topic_start   = 9'(hdr + 17'd2);
						r.topic_size    = head.word[6:0];
						r.payload_size  = pl[8:0];
						r.payload_start = (pl != 17'd0) ? pos[8:0] : 9'd0;
					end
					PT_PUBACK, PT_UNSUBACK: begin
						ok = flags == 4'd0 && head.rem == 16'd2 && head.word != 16'd0;
						r.pkt_ident = head.word;
					end
					PT_SUBACK: begin
						ok = flags == 4'd0 && head.rem >= 16'd3 && head.word != 16'd0
							&& (head.sub_rc == 8'd0 || head.sub_rc == 8'd1
							|| head.sub_rc == RC_FAIL);
						r.pkt_ident = head.word;
						r.ret_code  = head.sub_rc;
					end
					PT_PINGRESP: begin
						ok = flags == 4'd0 && head.rem == 16'd0;
					end
					default: begin
						ok = 1'b0;
					end
				endcase
				if (ok) begin
					r.status = ST_READY;
				end else begin
					r        = '0;
					r.status = ST_ERR;
				end
			end
			default: begin
				r.status = ST_MORE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (pop) begin
			vld_q <= 1'b1;
		end else if (out_ready) begin
			vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			res_q <= r;
		end
	end

endmodule

// ===== hdl/mqtt_client_packet_parser_core.sv =====
// MQTT 3.1.1 receive packet parser core: top level.
// Each request is a received byte (cmd 0) or a store read (cmd 1) and gives exactly one
// result in order: need more, error, packet ready with header fields, or read data. One
// request is taken per cycle; each request passes through the framing stage, which also
// registers the packet-store read, then waits in the four-entry queue ahead of the
// validation stage and its result register, which offers the result to the output.
// A stalled output fills the queue and then holds off new requests.
// No clearing pass is needed after reset.
module mqtt_client_packet_parser_core #(
	parameter int PACKET_MAX  = mcpp_pkg::PACKET_MAX_DEF,
	parameter int TOPIC_MAX   = mcpp_pkg::TOPIC_MAX_DEF,
	parameter int PAYLOAD_MAX = mcpp_pkg::PAYLOAD_MAX_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // cmd, data_byte[7:0], read_index[8:0], zero pad
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [79:0] m_tdata    // status, packet_type, header_flags, pkt_ident,
	                               // sess_flag, ret_code, topic_start,
	                               // topic_size, payload_start, payload_size, read_data, pad
);
	import mcpp_pkg::*;

	logic           acc, push, pop, not_empty;
	ent_t           push_ent, head;
	logic [QCW-1:0] count;
	res_t           res;

	assign s_tready = (32'(count) + 32'(push)) < 32'(QUEUE_DEPTH);
	assign acc      = s_tvalid && s_tready;
	assign m_tdata  = {3'd0, res};

	mcpp_front #(.PACKET_MAX(PACKET_MAX)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.acc        (acc),
		.cmd        (s_tdata[0]),
		.data_byte  (s_tdata[8:1]),
		.read_index (s_tdata[17:9]),
		.push       (push),
		.push_ent   (push_ent)
	);

	mcpp_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_ent  (push_ent),
		.pop       (pop),
		.not_empty (not_empty),
		.head      (head),
		.count     (count)
	);

	mcpp_back #(.TOPIC_MAX(TOPIC_MAX), .PAYLOAD_MAX(PAYLOAD_MAX)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.not_empty (not_empty),
		.head      (head),
		.pop       (pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.res       (res)
	);

endmodule

// ===== hdl/mcpp_checker.sv =====
// Port checker for the MQTT packet parser core and its bind.
module mcpp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [79:0] m_tdata
);
	import mcpp_pkg::*;

	a_reset_idle: assert property (@(posedge clk) !arst_n |-> !m_tvalid)
		else $error("result valid during reset");

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("result changed while stalled");

	a_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[1:0] != ST_READY |-> m_tdata[68:2] == '0)
		else $error("header fields set without packet ready");

	a_read_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[1:0] != ST_READ |-> m_tdata[79:69] == '0)
		else $error("read data set without read status");

endmodule

bind mqtt_client_packet_parser_core mcpp_checker u_mcpp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
